>>> rtl/core/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types and constants for the flow regulator supervisor.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int DRIVE_OFFSET = 8192;
   localparam int DRIVE_WIDTH  = 14;
   localparam int DRIVE_MAX    = (1 << DRIVE_WIDTH) - 1;
   localparam int SUM_WIDTH    = 17;

   localparam logic [DRIVE_WIDTH-1:0] DRIVE_IDLE =
      (DRIVE_OFFSET > DRIVE_MAX) ? DRIVE_WIDTH'(DRIVE_MAX) : DRIVE_WIDTH'(DRIVE_OFFSET);

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_EVAL  = 2'd2;
   localparam logic [1:0] KIND_OFF   = 2'd3;

   // result events
   localparam logic [1:0] EVT_NONE    = 2'd0;
   localparam logic [1:0] EVT_SETTLED = 2'd1;
   localparam logic [1:0] EVT_OFF     = 2'd2;

   // sequence phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_START  = 2'd1;
   localparam logic [1:0] PH_SETTLE = 2'd2;
   localparam logic [1:0] PH_MON    = 2'd3;

   // fault bit positions
   localparam int FLT_NO_SETTLE = 0;
   localparam int FLT_LARGE_ERR = 1;
   localparam int FLT_NO_REG    = 2;

   // control register indexes
   localparam logic [1:0] CSR_SMALL_TOL = 2'd0;
   localparam logic [1:0] CSR_LARGE_TOL = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd2;
   localparam logic [1:0] CSR_HOLD      = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [12:0] setpoint;
      logic [13:0] measured;
      logic        valve_select;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  small_tol;
      logic [7:0]  large_tol;
      logic [15:0] settle_timeout;
      logic [15:0] hold_time;
   } cfg_type;

   typedef struct packed {
      logic [1:0]             phase;
      logic [1:0]             event_res;
      logic                   fault_no_regulation;
      logic                   fault_large_error;
      logic                   fault_no_settle;
      logic                   ready_res;
      logic                   valve_one_open;
      logic                   valve_zero_open;
      logic [DRIVE_WIDTH-1:0] drive_code;
   } rsp_item_type;

endpackage

>>> rtl/core/frs_step.sv
// ----------------------------------------------------------------------------
// frs_step
// Sequence state and per-request update: counters, drive, valves, faults.
// ----------------------------------------------------------------------------
module frs_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  frs_pkg::req_item_type item,
   input  frs_pkg::cfg_type     cfg,
   output frs_pkg::rsp_item_type result
);

   logic [1:0]                       step_ff, step_in;
   logic [frs_pkg::COUNT_WIDTH-1:0]  settle_cnt_ff, settle_cnt_in;
   logic [frs_pkg::COUNT_WIDTH-1:0]  hold_cnt_ff, hold_cnt_in;
   logic [frs_pkg::DRIVE_WIDTH-1:0]  drive_ff, drive_in;
   logic [1:0]                       valve_ff, valve_in;
   logic                             ready_ff, ready_in;
   logic [2:0]                       fault_ff, fault_in;
   logic [1:0]                       event_in;

   logic [frs_pkg::SUM_WIDTH-1:0]    target_sum;
   logic [frs_pkg::DRIVE_WIDTH-1:0]  target;
   logic [13:0]                      err;
   logic [21:0]                      err_s;
   logic [21:0]                      small_b;
   logic [21:0]                      large_b;
   logic                             in_small;
   logic                             below_large;
   logic                             hold_done;
   logic                             timed_out;

   localparam logic [frs_pkg::COUNT_WIDTH-1:0] CNT_MAX = '1;

   assign target_sum = frs_pkg::SUM_WIDTH'(item.setpoint)
                     + frs_pkg::SUM_WIDTH'(frs_pkg::DRIVE_OFFSET);
   assign target = (target_sum > frs_pkg::SUM_WIDTH'(frs_pkg::DRIVE_MAX))
                 ? frs_pkg::DRIVE_WIDTH'(frs_pkg::DRIVE_MAX)
                 : target_sum[frs_pkg::DRIVE_WIDTH-1:0];

   assign err = (item.measured >= {1'b0, item.setpoint})
              ? item.measured - {1'b0, item.setpoint}
              : {1'b0, item.setpoint} - item.measured;
   assign err_s   = {err, 8'd0};
   assign small_b = 22'(item.setpoint) * 22'(cfg.small_tol);
   assign large_b = 22'(item.setpoint) * 22'(cfg.large_tol);
   assign in_small    = err_s <= small_b;
   assign below_large = err_s < large_b;
   assign hold_done = 33'(hold_cnt_ff) > 33'(cfg.hold_time);
   assign timed_out = 33'(settle_cnt_ff) > 33'(cfg.settle_timeout);

   always_comb begin
      step_in       = step_ff;
      settle_cnt_in = settle_cnt_ff;
      hold_cnt_in   = hold_cnt_ff;
      drive_in      = drive_ff;
      valve_in      = valve_ff;
      ready_in      = ready_ff;
      fault_in      = fault_ff;
      event_in      = frs_pkg::EVT_NONE;
      unique case (item.kind)
         frs_pkg::KIND_TICK: begin
            if (settle_cnt_ff != CNT_MAX) settle_cnt_in = settle_cnt_ff + 1'b1;
            if (hold_cnt_ff != CNT_MAX) hold_cnt_in = hold_cnt_ff + 1'b1;
         end
         frs_pkg::KIND_START: begin
            step_in = frs_pkg::PH_START;
         end
         frs_pkg::KIND_OFF: begin
            step_in  = frs_pkg::PH_IDLE;
            ready_in = 1'b0;
            fault_in = '0;
            valve_in = '0;
            drive_in = frs_pkg::DRIVE_IDLE;
            event_in = frs_pkg::EVT_OFF;
         end
         frs_pkg::KIND_EVAL: begin
            unique case (step_ff)
               frs_pkg::PH_IDLE: ;
               frs_pkg::PH_START: begin
                  drive_in      = target;
                  valve_in      = item.valve_select ? 2'b10 : 2'b01;
                  ready_in      = 1'b0;
                  fault_in      = '0;
                  settle_cnt_in = '0;
                  hold_cnt_in   = '0;
                  step_in       = frs_pkg::PH_SETTLE;
               end
               frs_pkg::PH_SETTLE: begin
                  priority if (drive_ff != target) begin
                     drive_in = target;
                  end else if (in_small) begin
                     if (hold_done) begin
                        fault_in[frs_pkg::FLT_NO_SETTLE] = 1'b0;
                        ready_in = 1'b1;
                        event_in = frs_pkg::EVT_SETTLED;
                        step_in  = frs_pkg::PH_MON;
                     end
                  end else begin
                     hold_cnt_in = '0;
                     if (timed_out) fault_in[frs_pkg::FLT_NO_SETTLE] = 1'b1;
                  end
               end
               frs_pkg::PH_MON: begin
                  priority if (drive_ff != target) begin
                     drive_in = target;
                  end else if (!in_small) begin
                     fault_in[frs_pkg::FLT_LARGE_ERR] = below_large;
                     fault_in[frs_pkg::FLT_NO_REG]    = !below_large;
                  end else begin
                     fault_in[frs_pkg::FLT_LARGE_ERR] = 1'b0;
                     fault_in[frs_pkg::FLT_NO_REG]    = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= frs_pkg::PH_IDLE;
         settle_cnt_ff <= '0;
         hold_cnt_ff   <= '0;
         drive_ff      <= frs_pkg::DRIVE_IDLE;
         valve_ff      <= '0;
         ready_ff      <= 1'b0;
         fault_ff      <= '0;
      end else if (step_en) begin
         step_ff       <= step_in;
         settle_cnt_ff <= settle_cnt_in;
         hold_cnt_ff   <= hold_cnt_in;
         drive_ff      <= drive_in;
         valve_ff      <= valve_in;
         ready_ff      <= ready_in;
         fault_ff      <= fault_in;
      end
   end

   always_comb begin
      result.drive_code          = drive_in;
      result.valve_zero_open     = valve_in[0];
      result.valve_one_open      = valve_in[1];
      result.ready_res           = ready_in;
      result.fault_no_settle     = fault_in[frs_pkg::FLT_NO_SETTLE];
      result.fault_large_error   = fault_in[frs_pkg::FLT_LARGE_ERR];
      result.fault_no_regulation = fault_in[frs_pkg::FLT_NO_REG];
      result.event_res           = event_in;
      result.phase               = step_in;
   end

   // monitoring is only reached with ready set
   a_mon_ready: assert property (@(posedge clock) disable iff (reset)
      step_ff == frs_pkg::PH_MON |-> ready_ff)
      else $error("monitoring without ready");

   // idle means valves closed, no ready, no faults
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      step_ff == frs_pkg::PH_IDLE |-> (valve_ff == 2'b00 && !ready_ff && fault_ff == 3'b000))
      else $error("idle with live outputs");

   // at most one valve open
   a_one_valve: assert property (@(posedge clock) disable iff (reset)
      valve_ff != 2'b11)
      else $error("both valves open");

   // settled event always lands in monitoring
   a_settle_evt: assert property (@(posedge clock) disable iff (reset)
      (step_en && event_in == frs_pkg::EVT_SETTLED) |=> step_ff == frs_pkg::PH_MON)
      else $error("settled event without monitoring");

endmodule

>>> rtl/core/flow_regulator_supervisor.sv
// ----------------------------------------------------------------------------
// flow_regulator_supervisor
// Supervises a mass-flow regulator through idle, start, settling, monitoring.
// ----------------------------------------------------------------------------
// channel  direction  ports              content
// req      in         req_t*             one request: tick/start/evaluate/off
// rsp      out        rsp_t*             one status result per request
// csr      in         csr_we/addr/wdata  tolerance, timeout and hold registers
//
// One request per cycle sustained while results are taken; the input
// register and the result register lie around the single update step.
// Reset is synchronous; it restores the register defaults and idles the
// sequence. A stalled result holds; the input register keeps taking a
// request while the result register waits, then stalls request acceptance.
// ----------------------------------------------------------------------------
module flow_regulator_supervisor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // setpoint[12:0], measured[26:13], valve_select[27]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // drive_code[13:0], valve_zero_open[14],
                                    // valve_one_open[15], ready_res[16],
                                    // fault_no_settle[17], fault_large_error[18],
                                    // fault_no_regulation[19], event_res[21:20],
                                    // phase[23:22]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   logic                   in_valid_ff;
   frs_pkg::req_item_type  in_item_ff;
   logic                   rsp_valid_ff;
   frs_pkg::rsp_item_type  rsp_item_ff;
   frs_pkg::cfg_type       cfg_ff;
   frs_pkg::rsp_item_type  step_result;
   logic                   advance;
   logic                   req_fire;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.kind         <= req_tuser;
         in_item_ff.setpoint     <= req_tdata[12:0];
         in_item_ff.measured     <= req_tdata[26:13];
         in_item_ff.valve_select <= req_tdata[27];
      end
   end

   frs_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_item_ff <= step_result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.small_tol      <= 8'd26;
         cfg_ff.large_tol      <= 8'd128;
         cfg_ff.settle_timeout <= 16'd10;
         cfg_ff.hold_time      <= 16'd3;
      end else if (csr_we) begin
         unique case (csr_addr)
            frs_pkg::CSR_SMALL_TOL: cfg_ff.small_tol      <= csr_wdata[7:0];
            frs_pkg::CSR_LARGE_TOL: cfg_ff.large_tol      <= csr_wdata[7:0];
            frs_pkg::CSR_TIMEOUT:   cfg_ff.settle_timeout <= csr_wdata;
            frs_pkg::CSR_HOLD:      cfg_ff.hold_time      <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

>>> tb/tb_flow_regulator_supervisor.sv
// ----------------------------------------------------------------------------
// tb_flow_regulator_supervisor
// Self-checking bench for the flow regulator supervisor. A short table of
// requests walks the sequence phases, then random request streams run
// under several register settings. A tick burst then runs against the
// widest timeout and hold settings. Every status result is compared against
// a cycle-free predictor of the sequence, or for typed table rows against
// the status given in the table. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_flow_regulator_supervisor;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_ROUNDS   = 8;
   localparam int ROUND_REQUESTS  = 235;
   localparam int PLAN_LEN        = 24;
   localparam int BURST_TICKS     = 40;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STALL_AFTER     = 400;
   localparam int STALL_CYCLES    = 300;

   typedef struct packed {
      logic [1:0]  kind;
      logic [12:0] setpoint;
      logic [13:0] measured;
      logic        valve_select;
      logic        typed;
      logic [1:0]  evt;
      logic [1:0]  ph;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = frs_pkg::KIND_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = frs_pkg::CSR_SMALL_TOL;
   logic [15:0] csr_wdata = '0;

   // predictor state
   frs_pkg::cfg_type                 cfg_now;
   logic [1:0]                       phase_now    = frs_pkg::PH_IDLE;
   logic [frs_pkg::COUNT_WIDTH-1:0]  settle_ticks = '0;
   logic [frs_pkg::COUNT_WIDTH-1:0]  hold_ticks   = '0;
   logic [frs_pkg::DRIVE_WIDTH-1:0]  drive_now    = frs_pkg::DRIVE_IDLE;
   logic [1:0]                       valves_now   = '0;
   logic                             ready_now    = 1'b0;
   logic [2:0]                       faults_now   = '0;

   frs_pkg::rsp_item_type pending_status[$];
   frs_pkg::rsp_item_type expected_st;
   int           mismatches = 0;
   int           results_seen = 0;
   int           cycle_count = 0;
   int           stall_left = 0;
   bit           stall_done = 1'b0;
   bit           gaps_on = 1'b1;
   logic [12:0]  session_setpoint = 13'd1000;

   plan_row_type opening_plan [PLAN_LEN] = '{
      {frs_pkg::KIND_TICK,  13'd0,    14'd0,     1'b0, 1'b1, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_EVAL,  13'd8191, 14'd16383, 1'b1, 1'b1, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_OFF,   13'd8191, 14'd16383, 1'b1, 1'b1, frs_pkg::EVT_OFF,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_START, 13'd0,    14'd0,     1'b0, 1'b1, frs_pkg::EVT_NONE,
       frs_pkg::PH_START},
      {frs_pkg::KIND_EVAL,  13'd8191, 14'd8191,  1'b1, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_TICK,  13'd0,    14'd0,     1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_TICK,  13'd0,    14'd0,     1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_TICK,  13'd0,    14'd0,     1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_EVAL,  13'd8191, 14'd8191,  1'b1, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_TICK,  13'd0,    14'd0,     1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_EVAL,  13'd8191, 14'd8000,  1'b1, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_EVAL,  13'd8191, 14'd16383, 1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_EVAL,  13'd8191, 14'd7191,  1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_EVAL,  13'd8191, 14'd8191,  1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_EVAL,  13'd0,    14'd0,     1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_EVAL,  13'd0,    14'd1,     1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_OFF,   13'd0,    14'd0,     1'b0, 1'b1, frs_pkg::EVT_OFF,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_START, 13'd0,    14'd0,     1'b0, 1'b1, frs_pkg::EVT_NONE,
       frs_pkg::PH_START},
      {frs_pkg::KIND_EVAL,  13'd100,  14'd0,     1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_TICK,  13'd0,    14'd0,     1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_EVAL,  13'd100,  14'd0,     1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_EVAL,  13'd4000, 14'd4000,  1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_TICK,  13'd0,    14'd0,     1'b0, 1'b0, frs_pkg::EVT_NONE,
       frs_pkg::PH_IDLE},
      {frs_pkg::KIND_OFF,   13'd0,    14'd0,     1'b0, 1'b1, frs_pkg::EVT_OFF,
       frs_pkg::PH_IDLE}
   };

   flow_regulator_supervisor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic frs_pkg::req_item_type make_req(input logic [1:0] kind, input int sp,
                                                      input int meas, input bit sel);
      frs_pkg::req_item_type it;
      it.kind = kind;
      it.setpoint = 13'(sp);
      it.measured = 14'(meas);
      it.valve_select = sel;
      return it;
   endfunction

   // next status of the supervisor for one request
   function automatic frs_pkg::rsp_item_type regulate(input frs_pkg::req_item_type it);
      frs_pkg::rsp_item_type st;
      int unsigned target, err, err_sc, small_b, large_b;
      logic [1:0] evt;
      target = it.setpoint + frs_pkg::DRIVE_OFFSET;
      if (target > frs_pkg::DRIVE_MAX) target = frs_pkg::DRIVE_MAX;
      err = (it.measured >= it.setpoint) ? it.measured - it.setpoint
                                         : it.setpoint - it.measured;
      err_sc = err * 256;
      small_b = it.setpoint * cfg_now.small_tol;
      large_b = it.setpoint * cfg_now.large_tol;
      evt = frs_pkg::EVT_NONE;
      case (it.kind)
         frs_pkg::KIND_TICK: begin
            if (settle_ticks != '1) settle_ticks = settle_ticks + 1'b1;
            if (hold_ticks != '1) hold_ticks = hold_ticks + 1'b1;
         end
         frs_pkg::KIND_START: phase_now = frs_pkg::PH_START;
         frs_pkg::KIND_OFF: begin
            phase_now = frs_pkg::PH_IDLE;
            ready_now = 1'b0;
            faults_now = '0;
            valves_now = '0;
            drive_now = frs_pkg::DRIVE_IDLE;
            evt = frs_pkg::EVT_OFF;
         end
         default: begin
            if (phase_now == frs_pkg::PH_START) begin
               drive_now = frs_pkg::DRIVE_WIDTH'(target);
               valves_now = it.valve_select ? 2'b10 : 2'b01;
               ready_now = 1'b0;
               faults_now = '0;
               settle_ticks = '0;
               hold_ticks = '0;
               phase_now = frs_pkg::PH_SETTLE;
            end else if (phase_now == frs_pkg::PH_SETTLE) begin
               if (drive_now != target) begin
                  drive_now = frs_pkg::DRIVE_WIDTH'(target);
               end else if (err_sc <= small_b) begin
                  if (hold_ticks > cfg_now.hold_time) begin
                     faults_now[frs_pkg::FLT_NO_SETTLE] = 1'b0;
                     ready_now = 1'b1;
                     evt = frs_pkg::EVT_SETTLED;
                     phase_now = frs_pkg::PH_MON;
                  end
               end else begin
                  hold_ticks = '0;
                  if (settle_ticks > cfg_now.settle_timeout)
                     faults_now[frs_pkg::FLT_NO_SETTLE] = 1'b1;
               end
            end else if (phase_now == frs_pkg::PH_MON) begin
               if (drive_now != target) begin
                  drive_now = frs_pkg::DRIVE_WIDTH'(target);
               end else if (err_sc > small_b) begin
                  faults_now[frs_pkg::FLT_LARGE_ERR] = (err_sc < large_b);
                  faults_now[frs_pkg::FLT_NO_REG] = !(err_sc < large_b);
               end else begin
                  faults_now[frs_pkg::FLT_LARGE_ERR] = 1'b0;
                  faults_now[frs_pkg::FLT_NO_REG] = 1'b0;
               end
            end
         end
      endcase
      st.drive_code = drive_now;
      st.valve_zero_open = valves_now[0];
      st.valve_one_open = valves_now[1];
      st.ready_res = ready_now;
      st.fault_no_settle = faults_now[frs_pkg::FLT_NO_SETTLE];
      st.fault_large_error = faults_now[frs_pkg::FLT_LARGE_ERR];
      st.fault_no_regulation = faults_now[frs_pkg::FLT_NO_REG];
      st.event_res = evt;
      st.phase = phase_now;
      return st;
   endfunction

   // mostly well-formed regulation traffic around a session setpoint
   function automatic frs_pkg::req_item_type random_req();
      frs_pkg::req_item_type it;
      int r, d, m;
      r = $urandom_range(0, 99);
      it.setpoint = 13'($urandom);
      it.measured = 14'($urandom);
      it.valve_select = 1'($urandom_range(0, 1));
      if (r < 3) begin
         it.kind = frs_pkg::KIND_OFF;
      end else if (r < 8) begin
         it.kind = frs_pkg::KIND_START;
      end else if (r < 40) begin
         it.kind = frs_pkg::KIND_TICK;
      end else begin
         it.kind = frs_pkg::KIND_EVAL;
         if (r >= 45) begin
            if ($urandom_range(0, 19) == 0) begin
               case ($urandom_range(0, 3))
                  0: session_setpoint = 13'd0;
                  1: session_setpoint = 13'd8191;
                  default: session_setpoint = 13'($urandom);
               endcase
            end
            it.setpoint = session_setpoint;
            d = $urandom_range(0, session_setpoint / 4 + 2);
            case ($urandom_range(0, 3))
               0: m = session_setpoint;
               1: m = session_setpoint + d;
               2: m = (d > session_setpoint) ? 0 : session_setpoint - d;
               default: m = $urandom_range(0, 16383);
            endcase
            it.measured = 14'(m);
         end
      end
      return it;
   endfunction

   task automatic send_req(input frs_pkg::req_item_type it, input bit typed = 1'b0,
                           input frs_pkg::rsp_item_type typed_st = '0);
      bit accepted;
      frs_pkg::rsp_item_type st;
      while (gaps_on && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {4'b0, it.valve_select, it.measured, it.setpoint};
      accepted = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = req_tready;
      end
      st = regulate(it);
      pending_status.push_back(typed ? typed_st : st);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      case (addr)
         frs_pkg::CSR_SMALL_TOL: cfg_now.small_tol = data[7:0];
         frs_pkg::CSR_LARGE_TOL: cfg_now.large_tol = data[7:0];
         frs_pkg::CSR_TIMEOUT:   cfg_now.settle_timeout = data;
         default:                cfg_now.hold_time = data;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input frs_pkg::cfg_type c);
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      write_reg(frs_pkg::CSR_SMALL_TOL, {8'd0, c.small_tol});
      write_reg(frs_pkg::CSR_LARGE_TOL, {8'd0, c.large_tol});
      write_reg(frs_pkg::CSR_TIMEOUT, c.settle_timeout);
      write_reg(frs_pkg::CSR_HOLD, c.hold_time);
      csr_we <= 1'b0;
   endtask

   function automatic int field_diff(input string name, input int unsigned e,
                                     input int unsigned a);
      if (e != a) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random backpressure plus one long hold-off
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!stall_done && results_seen >= STALL_AFTER) begin
         stall_done <= 1'b1;
         stall_left <= STALL_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= gaps_on ? ($urandom_range(0, 99) >= 21) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (pending_status.size() == 0) begin
            $display("%0t: status %h arrived with no request outstanding", $time, rsp_tdata);
            mismatches = mismatches + 1;
         end else begin
            expected_st = pending_status.pop_front();
            mismatches = mismatches
               + field_diff("drive_code", expected_st.drive_code, rsp_tdata[13:0])
               + field_diff("valve_zero_open", expected_st.valve_zero_open, rsp_tdata[14])
               + field_diff("valve_one_open", expected_st.valve_one_open, rsp_tdata[15])
               + field_diff("ready_res", expected_st.ready_res, rsp_tdata[16])
               + field_diff("fault_no_settle", expected_st.fault_no_settle, rsp_tdata[17])
               + field_diff("fault_large_error", expected_st.fault_large_error, rsp_tdata[18])
               + field_diff("fault_no_regulation", expected_st.fault_no_regulation,
                            rsp_tdata[19])
               + field_diff("event_res", expected_st.event_res, rsp_tdata[21:20])
               + field_diff("phase", expected_st.phase, rsp_tdata[23:22]);
         end
      end
   end

   initial begin
      frs_pkg::rsp_item_type idle_st;
      frs_pkg::cfg_type      c;
      cfg_now.small_tol = 8'd26;
      cfg_now.large_tol = 8'd128;
      cfg_now.settle_timeout = 16'd10;
      cfg_now.hold_time = 16'd3;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i]) begin
         idle_st = '0;
         idle_st.drive_code = frs_pkg::DRIVE_IDLE;
         idle_st.event_res = opening_plan[i].evt;
         idle_st.phase = opening_plan[i].ph;
         send_req(make_req(opening_plan[i].kind, opening_plan[i].setpoint,
                           opening_plan[i].measured, opening_plan[i].valve_select),
                  opening_plan[i].typed, idle_st);
      end

      for (int r = 0; r < RANDOM_ROUNDS; r++) begin
         case (r)
            0: c = '{small_tol: 8'd0, large_tol: 8'd255, settle_timeout: 16'd0,
                     hold_time: 16'd0};
            1: c = '{small_tol: 8'd255, large_tol: 8'd0, settle_timeout: 16'd65535,
                     hold_time: 16'd65535};
            7: c = '{small_tol: 8'($urandom), large_tol: 8'($urandom),
                     settle_timeout: 16'($urandom_range(0, 40)),
                     hold_time: 16'($urandom_range(0, 8))};
            default: c = '{small_tol: 8'($urandom_range(10, 60)),
                           large_tol: 8'($urandom_range(61, 255)),
                           settle_timeout: 16'($urandom_range(0, 25)),
                           hold_time: 16'($urandom_range(0, 6))};
         endcase
         apply_settings(c);
         gaps_on = (r != 3);
         for (int n = 0; n < ROUND_REQUESTS; n++) send_req(random_req());
      end

      // tick burst against the widest timeout and hold settings
      gaps_on = 1'b1;
      apply_settings('{small_tol: 8'd26, large_tol: 8'd128, settle_timeout: 16'd65535,
                       hold_time: 16'd65535});
      send_req(make_req(frs_pkg::KIND_START, 0, 0, 1'b0));
      send_req(make_req(frs_pkg::KIND_EVAL, 4000, 4000, 1'b1));
      for (int n = 0; n < BURST_TICKS; n++) send_req(make_req(frs_pkg::KIND_TICK, 0, 0, 1'b0));
      send_req(make_req(frs_pkg::KIND_EVAL, 4000, 4000, 1'b1));
      send_req(make_req(frs_pkg::KIND_EVAL, 4000, 0, 1'b1));
      apply_settings('{small_tol: 8'd26, large_tol: 8'd128, settle_timeout: 16'd65534,
                       hold_time: 16'd65535});
      send_req(make_req(frs_pkg::KIND_EVAL, 4000, 0, 1'b1));

      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
